/* design/mwalu_pkg.sv */
// ----------------------------------------------------------------------------
// mwalu_pkg: shared definitions for the multiword bit vector ALU
// Holds the command codes, the sizing constants and the cell control struct.
// ----------------------------------------------------------------------------
package mwalu_pkg;

    localparam int WORDS      = 16;
    localparam int WORD_BITS  = 64;
    localparam int WIDX_BITS  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BPOS_BITS  = $clog2(WORD_BITS);
    localparam int TOTAL_BITS = WORDS * WORD_BITS;
    localparam int STEP_BITS  = $clog2(WORDS + 1);

    typedef enum logic [3:0] {
        CMD_LOAD   = 4'd0,
        CMD_ADD    = 4'd1,
        CMD_SUB    = 4'd2,
        CMD_OR     = 4'd3,
        CMD_AND    = 4'd4,
        CMD_XOR    = 4'd5,
        CMD_NOT    = 4'd6,
        CMD_SHL    = 4'd7,
        CMD_SHR    = 4'd8,
        CMD_SETBIT = 4'd9,
        CMD_GETBIT = 4'd10,
        CMD_READ   = 4'd11
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_BIT
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic                 rotate;    // advance the ring by one word
        logic                 left;      // direction of the ring move
        logic                 clear;     // clear every word
        logic                 wr_en;     // write one word
        logic [WIDX_BITS-1:0] wr_idx;
        logic [WORD_BITS-1:0] wr_data;
        logic                 sh_en;     // bit shift within the ring move
        logic [BPOS_BITS-1:0] sh_bits;
    } cell_ctrl_t;

endpackage

/* design/mwalu_if.sv */
// ----------------------------------------------------------------------------
// mwalu_if: valid/ready channel
// Generic request channel with a payload of parameterised type.
// ----------------------------------------------------------------------------
interface mwalu_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/multiword_bitvector_alu.sv */
// ----------------------------------------------------------------------------
// multiword_bitvector_alu: wide vector ALU built as a row of word cells
// Word commands act on one cell per request; shifts move words cell to cell.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | command, word_index, operand_word, shift_amount, bit_index,
//          |     | bit_flag
//  rsp     | out | result_word, bit_value, carry_out
//
//  Word commands, set, get and read are taken back to back while no response
//  waits. A shift: the accepting cycle, then the ring moves one word per cycle
//  for each whole word moved, and a final pass carries the bit shift; an
//  amount of the whole vector or more is a clear in the accepting cycle.
//  After reset a single clearing cycle empties the vector; no request taken.
//  A waiting response holds the request side only when the output is full.
// ----------------------------------------------------------------------------
module multiword_bitvector_alu
    import mwalu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mwalu_if.sink   req,
    mwalu_if.source rsp
);
    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  word_index;
        logic [63:0] operand_word;
        logic [10:0] shift_amount;
        logic [9:0]  bit_index;
        logic        bit_flag;
    } req_t;
    typedef struct packed {
        logic [63:0] result_word;
        logic        bit_value;
        logic        carry_out;
    } rsp_t;

    req_t r;
    assign r = req.payload;

    logic [WORD_BITS-1:0] words [WORDS];
    cell_ctrl_t ctrl;

    logic                 init_reg;
    logic                 busy_reg, busy_next;
    logic                 left_reg, left_next;
    logic [STEP_BITS-1:0] steps_reg, steps_next;
    logic [BPOS_BITS-1:0] bits_reg, bits_next;
    logic                 carry_reg, carry_next;
    logic                 ovalid_reg, ovalid_next;
    rsp_t                 odata_reg, odata_next;

    logic accept, word_cmd, idx_ok, bit_ok, cin;
    logic [WORD_BITS-1:0] a, opw, m, res;
    logic [WORD_BITS:0]   sum;
    logic [WIDX_BITS-1:0] widx, bw;
    logic [BPOS_BITS-1:0] bb;
    logic [10:0]          q;

    // row of cells; the far neighbour carries the spilled bits
    for (genvar i = 0; i < WORDS; i++)
    begin : g_cell
        localparam int NL = i - 1, NR = i + 1;
        logic [WORD_BITS-1:0] nw, fw;
        logic nok, fok;
        always_comb
        begin
            if (ctrl.left)
            begin
                nok = (i >= 1) && !ctrl.sh_en;
                fok = (i >= 1);
                nw  = (i >= 1) ? words[(i >= 1) ? NL : 0] : '0;
                fw  = nw;
                if (ctrl.sh_en)
                begin
                    nok = 1'b1;
                    nw  = words[i];
                end
            end
            else
            begin
                nok = (NR < WORDS) && !ctrl.sh_en;
                fok = (NR < WORDS);
                nw  = words[(NR < WORDS) ? NR : i];
                fw  = nw;
                if (ctrl.sh_en)
                begin
                    nok = 1'b1;
                    nw  = words[i];
                end
            end
        end
        mwalu_cell u_cell (
            .clk(clk), .my_idx(WIDX_BITS'(i)), .ctrl(ctrl),
            .near_word(nw), .far_word(fw), .near_ok(nok), .far_ok(fok),
            .word(words[i])
        );
    end

    assign widx   = r.word_index[WIDX_BITS-1:0];
    assign idx_ok = ({28'd0, r.word_index} < 32'(WORDS));
    assign bw     = WIDX_BITS'(r.bit_index >> BPOS_BITS);
    assign bb     = r.bit_index[BPOS_BITS-1:0];
    assign bit_ok = ({22'd0, r.bit_index} < 32'(TOTAL_BITS));
    assign q      = r.shift_amount >> BPOS_BITS;
    assign opw    = r.operand_word[WORD_BITS-1:0];
    assign a      = words[idx_ok ? widx : '0];
    assign cin    = (r.word_index != 4'd0) && carry_reg;
    assign word_cmd = (r.command <= CMD_NOT) || (r.command == CMD_READ);

    assign req.ready = init_reg && !busy_reg && (!ovalid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        sum = '0;
        res = a;
        unique case (r.command)
            CMD_LOAD: res = opw;
            CMD_ADD:
            begin
                sum = {1'b0, a} + {1'b0, opw} + (WORD_BITS+1)'(cin);
                res = sum[WORD_BITS-1:0];
            end
            CMD_SUB:
            begin
                sum = {1'b0, a} - {1'b0, opw} - (WORD_BITS+1)'(cin);
                res = sum[WORD_BITS-1:0];
            end
            CMD_OR:  res = a | opw;
            CMD_AND: res = a & opw;
            CMD_XOR: res = a ^ opw;
            CMD_NOT: res = ~a;
            default: res = a;
        endcase
        m = words[bw] | (WORD_BITS'(1) << bb);
        if (!r.bit_flag)
            m = words[bw] & ~(WORD_BITS'(1) << bb);
    end

    // sequencer and response register
    always_comb
    begin
        busy_next   = busy_reg;
        left_next   = left_reg;
        steps_next  = steps_reg;
        bits_next   = bits_reg;
        carry_next  = carry_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        odata_next  = odata_reg;
        ctrl        = '0;
        ctrl.left   = left_reg;
        if (!init_reg)
            ctrl.clear = 1'b1;
        else if (busy_reg)
        begin
            ctrl.rotate = 1'b1;
            if (steps_reg == '0)
            begin
                ctrl.sh_en   = 1'b1;
                ctrl.sh_bits = bits_reg;
                busy_next    = 1'b0;
            end
            else
                steps_next = steps_reg - 1'b1;
        end
        else if (accept)
        begin
            ovalid_next = 1'b1;
            odata_next  = '0;
            if (word_cmd)
            begin
                if (idx_ok)
                begin
                    ctrl.wr_en   = 1'b1;
                    ctrl.wr_idx  = widx;
                    ctrl.wr_data = res;
                    odata_next.result_word = 64'(res);
                    if (r.command == CMD_ADD)
                    begin
                        carry_next = sum[WORD_BITS];
                        odata_next.carry_out = sum[WORD_BITS];
                    end
                    else if (r.command == CMD_SUB)
                    begin
                        carry_next = sum[WORD_BITS];
                        odata_next.carry_out = sum[WORD_BITS];
                    end
                end
            end
            else if (r.command == CMD_SHL || r.command == CMD_SHR)
            begin
                if ({21'd0, r.shift_amount} >= 32'(TOTAL_BITS))
                    ctrl.clear = 1'b1;
                else
                begin
                    busy_next  = 1'b1;
                    left_next  = (r.command == CMD_SHL);
                    steps_next = STEP_BITS'(q);
                    bits_next  = r.shift_amount[BPOS_BITS-1:0];
                end
            end
            else if (r.command == CMD_SETBIT && bit_ok)
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_idx  = bw;
                ctrl.wr_data = m;
            end
            else if (r.command == CMD_GETBIT && bit_ok)
                odata_next.bit_value = words[bw][bb];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            left_reg   <= 1'b0;
            steps_reg  <= '0;
            bits_reg   <= '0;
            carry_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            init_reg   <= 1'b1;
            busy_reg   <= busy_next;
            left_reg   <= left_next;
            steps_reg  <= steps_next;
            bits_reg   <= bits_next;
            carry_reg  <= carry_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
        odata_reg <= odata_next;

    assign rsp.valid   = ovalid_reg;
    assign rsp.payload = odata_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.ready) else $error("request taken during shift");
    a_hold_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(odata_reg))
        else $error("response dropped");
    a_accept_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid) else $error("no response for request");
`endif
endmodule

/* design/mwalu_cell.sv */
// ----------------------------------------------------------------------------
// mwalu_cell: one word of the vector
// Holds a word; takes its neighbour's words during a ring move.
// ----------------------------------------------------------------------------
module mwalu_cell
    import mwalu_pkg::*;
(
    input  logic                 clk,
    input  logic [WIDX_BITS-1:0] my_idx,
    input  cell_ctrl_t           ctrl,
    input  logic [WORD_BITS-1:0] near_word,  // neighbour the word comes from
    input  logic [WORD_BITS-1:0] far_word,   // the one beyond, for spilled bits
    input  logic                 near_ok,
    input  logic                 far_ok,
    output logic [WORD_BITS-1:0] word
);
    logic [WORD_BITS-1:0] word_reg, word_next, n_w, f_w, spill;
    logic [BPOS_BITS:0]   back;

    always_comb
    begin
        n_w  = near_ok ? near_word : '0;
        f_w  = far_ok  ? far_word  : '0;
        back = (BPOS_BITS+1)'(WORD_BITS) - {1'b0, ctrl.sh_bits};
        if (!ctrl.sh_en)
            spill = '0;
        else if (ctrl.left)
            spill = f_w >> back;
        else
            spill = f_w << back;
        word_next = word_reg;
        if (ctrl.clear)
            word_next = '0;
        else if (ctrl.rotate)
        begin
            if (!ctrl.sh_en)
                word_next = n_w;
            else if (ctrl.left)
                word_next = (n_w << ctrl.sh_bits) | spill;
            else
                word_next = (n_w >> ctrl.sh_bits) | spill;
        end
        else if (ctrl.wr_en && ctrl.wr_idx == my_idx)
            word_next = ctrl.wr_data;
    end

    // reset clearing is done through ctrl.clear by the controller
    always_ff @(posedge clk)
        word_reg <= word_next;

    assign word = word_reg;
endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for multiword_bitvector_alu
// Streams directed and random requests through the valid/ready channel,
// predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
    import mwalu_pkg::*;

    typedef struct packed {
        cmd_t        command;
        logic [3:0]  word_index;
        logic [63:0] operand_word;
        logic [10:0] shift_amount;
        logic [9:0]  bit_index;
        logic        bit_flag;
    } alu_req_t;

    typedef struct packed {
        logic [63:0] result_word;
        logic        bit_value;
        logic        carry_out;
    } alu_rsp_t;

    // scoreboard: keeps a copy of the wide vector and the queue of expected responses
    class alu_scoreboard;
        logic [WORD_BITS-1:0] vec [WORDS];
        logic                 carry;
        alu_rsp_t             expected_q [$];
        int                   errors;
        int                   checked;

        function void clear_state();
            for (int i = 0; i < WORDS; i++)
                vec[i] = '0;
            carry = 1'b0;
        endfunction

        // predict the response of one accepted request and advance the copy
        function void note(alu_req_t r);
            alu_rsp_t             e;
            logic [WORD_BITS-1:0] a;
            logic [WORD_BITS:0]   wide;
            logic                 cin;
            logic [TOTAL_BITS-1:0] flat;
            int                   w;
            int                   b;
            e = '0;
            case (r.command)
                CMD_LOAD, CMD_ADD, CMD_SUB, CMD_OR, CMD_AND, CMD_XOR, CMD_NOT, CMD_READ:
                begin
                    a   = vec[r.word_index];
                    cin = (r.word_index == 0) ? 1'b0 : carry;
                    case (r.command)
                        CMD_LOAD: a = r.operand_word;
                        CMD_ADD:
                        begin
                            wide = {1'b0, a} + {1'b0, r.operand_word} + cin;
                            a = wide[WORD_BITS-1:0];
                            e.carry_out = wide[WORD_BITS];
                            carry = wide[WORD_BITS];
                        end
                        CMD_SUB:
                        begin
                            e.carry_out = (a < r.operand_word) ||
                                          (a == r.operand_word && cin);
                            a = a - r.operand_word - cin;
                            carry = e.carry_out;
                        end
                        CMD_OR:  a = a | r.operand_word;
                        CMD_AND: a = a & r.operand_word;
                        CMD_XOR: a = a ^ r.operand_word;
                        CMD_NOT: a = ~a;
                        default: ;
                    endcase
                    vec[r.word_index] = a;
                    e.result_word = a;
                end
                CMD_SHL, CMD_SHR:
                begin
                    for (int i = 0; i < WORDS; i++)
                        flat[i*WORD_BITS +: WORD_BITS] = vec[i];
                    if (r.shift_amount >= TOTAL_BITS)
                        flat = '0;
                    else if (r.command == CMD_SHL)
                        flat = flat << r.shift_amount;
                    else
                        flat = flat >> r.shift_amount;
                    for (int i = 0; i < WORDS; i++)
                        vec[i] = flat[i*WORD_BITS +: WORD_BITS];
                end
                CMD_SETBIT, CMD_GETBIT:
                begin
                    w = r.bit_index / WORD_BITS;
                    b = r.bit_index % WORD_BITS;
                    if (r.command == CMD_SETBIT)
                        vec[w][b] = r.bit_flag;
                    else
                        e.bit_value = vec[w][b];
                end
                default: ;
            endcase
            expected_q.push_back(e);
        endfunction

        function void check(alu_rsp_t got);
            alu_rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("response with nothing expected: word %h", got.result_word);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.result_word !== e.result_word)
            begin
                $error("result_word: expected %h, got %h", e.result_word, got.result_word);
                errors++;
            end
            if (got.bit_value !== e.bit_value)
            begin
                $error("bit_value: expected %b, got %b", e.bit_value, got.bit_value);
                errors++;
            end
            if (got.carry_out !== e.carry_out)
            begin
                $error("carry_out: expected %b, got %b", e.carry_out, got.carry_out);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mwalu_if #(.payload_t(alu_req_t)) req ();
    mwalu_if #(.payload_t(alu_rsp_t)) rsp ();

    multiword_bitvector_alu DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    alu_scoreboard alu_sb;
    int            burst_left;
    int            sent_count;
    int            stall_mode;
    int            stall_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #3_000_000;
        $display("multiword_bitvector_alu test failed");
        $finish;
    end

    // Sample both channels at the edge: a request counts when valid and ready
    // were both high just before it. Note the request before checking so a
    // same-edge response can never overtake its own prediction.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            alu_sb.note(req.payload);
        if (rst_n && rsp.valid && rsp.ready)
            alu_sb.check(rsp.payload);
    end

    // Receiver back-pressure: its own pattern, switching between always ready,
    // sparse stalls, heavy stalls and a fixed on/off rhythm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready   <= 1'b0;
            stall_mode  <= 0;
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       rsp.ready <= 1'b1;
                1:       rsp.ready <= ($urandom_range(0, 7) != 0);
                2:       rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= stall_count[1];
            endcase
        end
    end

    // Send one request; the sender works in bursts, and only between bursts
    // does valid drop for a random gap. Valid stays high across a burst.
    task automatic send_request(input alu_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        req.valid   <= 1'b1;
        req.payload <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        burst_left--;
        sent_count++;
    endtask

    task automatic send_cmd(input cmd_t c, input int idx, input logic [63:0] opw,
                            input int amt, input int bidx, input logic flag);
        alu_req_t r;
        r.command      = c;
        r.word_index   = 4'(idx);
        r.operand_word = opw;
        r.shift_amount = 11'(amt);
        r.bit_index    = 10'(bidx);
        r.bit_flag     = flag;
        send_request(r);
    endtask

    function automatic logic [63:0] rand_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1;
            default: ;
        endcase
        return v;
    endfunction

    function automatic int rand_amount();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 63);
            1: return $urandom_range(0, 4) * 64;
            2: return $urandom_range(1000, 1024);
            default: return $urandom_range(0, 1024);
        endcase
    endfunction

    // A well-formed multiword operation: a word command streamed over a run
    // of words, lowest word first, so carries chain from word to word along the run.
    task automatic stream_vector(input cmd_t c);
        int top;
        top = $urandom_range(0, WORDS - 1);
        for (int i = 0; i <= top; i++)
            send_cmd(c, i, rand_word(), 0, 0, 1'b0);
    endtask

    initial
    begin
        alu_sb = new();
        alu_sb.clear_state();
        alu_sb.errors  = 0;
        alu_sb.checked = 0;
        burst_left  = 0;
        sent_count  = 0;
        req.valid   = 1'b0;
        req.payload = '0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: carry through all-ones words, borrow through zero
        send_cmd(CMD_LOAD, 0, '1, 0, 0, 1'b0);
        send_cmd(CMD_LOAD, 15, '1, 0, 0, 1'b0);
        send_cmd(CMD_ADD, 0, 64'd1, 0, 0, 1'b0);
        send_cmd(CMD_ADD, 1, '1, 0, 0, 1'b0);
        send_cmd(CMD_SUB, 0, 64'd1, 0, 0, 1'b0);
        send_cmd(CMD_SUB, 1, '0, 0, 0, 1'b0);
        send_cmd(CMD_OR, 2, 64'hA5A5_5A5A_F0F0_0F0F, 0, 0, 1'b0);
        send_cmd(CMD_AND, 2, 64'hFFFF_0000_FFFF_0000, 0, 0, 1'b0);
        send_cmd(CMD_XOR, 2, '1, 0, 0, 1'b0);
        send_cmd(CMD_NOT, 3, 64'h1234, 0, 0, 1'b0);
        send_cmd(CMD_READ, 15, '0, 0, 0, 1'b0);
        send_cmd(CMD_SHL, 0, '0, 1, 0, 1'b0);
        send_cmd(CMD_SHR, 0, '0, 63, 0, 1'b0);
        send_cmd(CMD_SHL, 0, '0, 64, 0, 1'b0);
        send_cmd(CMD_SHR, 0, '0, 1023, 0, 1'b0);
        send_cmd(CMD_SETBIT, 0, '0, 0, 1023, 1'b1);
        send_cmd(CMD_SETBIT, 0, '0, 0, 0, 1'b1);
        send_cmd(CMD_GETBIT, 0, '0, 0, 1023, 1'b0);
        send_cmd(CMD_SHR, 0, '0, 0, 0, 1'b0);
        send_cmd(CMD_SETBIT, 0, '0, 0, 1023, 1'b0);
        send_cmd(CMD_GETBIT, 0, '0, 0, 0, 1'b0);
        send_cmd(CMD_SHL, 0, '0, 1024, 0, 1'b0);
        send_cmd(CMD_READ, 0, '0, 0, 0, 1'b0);

        // random: mostly streamed vector operations, the rest single requests
        while (sent_count < 700)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: stream_vector(cmd_t'($urandom_range(0, 2)));
                3:       stream_vector(cmd_t'($urandom_range(3, 6)));
                4:       send_cmd(cmd_t'($urandom_range(7, 8)), $urandom_range(0, 15),
                                  rand_word(), rand_amount(), $urandom_range(0, 1023),
                                  1'($urandom_range(0, 1)));
                5, 6:    send_cmd(cmd_t'($urandom_range(9, 10)), $urandom_range(0, 15),
                                  rand_word(), rand_amount(), $urandom_range(0, 1023),
                                  1'($urandom_range(0, 1)));
                default: send_cmd(cmd_t'($urandom_range(0, 11)), $urandom_range(0, 15),
                                  rand_word(), rand_amount(), $urandom_range(0, 1023),
                                  1'($urandom_range(0, 1)));
            endcase
        end
        req.valid <= 1'b0;

        // drain, then keep the clock running for any stray response
        while (alu_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d requests across every command; %0d responses compared.",
                 sent_count, alu_sb.checked);
        if (alu_sb.errors == 0 && alu_sb.expected_q.size() == 0)
            $display("multiword_bitvector_alu test passed");
        else
            $display("multiword_bitvector_alu test failed");
        $finish;
    end
endmodule

/* multiword_bitvector_alu.f */
design/mwalu_pkg.sv
design/mwalu_if.sv
design/mwalu_cell.sv
design/multiword_bitvector_alu.sv
tb/sv/tb.sv
